/* rtl/bps_pkg.sv */
// shared types and constants of the beep pattern sequencer
`timescale 1ns / 1ps

package bps_pkg;

    localparam int unsigned CNT_W       = 8;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 16;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [S_TUSER_W-1:0] {
        KIND_BEEP_REQ   = 2'd0,
        KIND_SLOW_TICK  = 2'd1,
        KIND_TONE_TICK  = 2'd2,
        KIND_UNUSED     = 2'd3
    } kind_t;

endpackage

/* rtl/beep_pattern_sequencer_core.sv */
// buzzer beep pattern sequencer, single-pass stream core
`timescale 1ns / 1ps

//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+-------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | kind, beep/on/off lengths, mute
//  m_      | out | m_tvalid m_tready m_tdata      | pin level, sounding, beeps remaining
//
//  each request passes through the input register and then the result register,
//  and one request is taken every cycle while results are taken or the result register is free
//  the rate is set by the single state update between the two registers
//  aresetn is synchronous, active low, and clears the state counters, flags and valids
//  a stalled result holds the result register; the input register fills behind it,
//  after which s_tready drops until the result is taken

module beep_pattern_sequencer_core
    import bps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] beep_count, [15:8] on_ticks, [23:16] off_ticks, [24] mute, [31:25] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] pin_level, [1] sounding, [9:2] beeps_remaining, [15:10] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // input register
    logic                 in_valid_reg, in_valid_next;
    kind_t                in_kind_reg;
    cnt_t                 in_beeps_reg, in_on_reg, in_off_reg;
    logic                 in_mute_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_pin_reg, out_sound_reg;
    cnt_t                 out_beeps_reg;

    // sequencer state
    cnt_t on_left_reg, on_left_next;
    cnt_t off_left_reg, off_left_next;
    cnt_t beeps_left_reg, beeps_left_next;
    cnt_t on_reload_reg, on_reload_next;
    cnt_t off_reload_reg, off_reload_next;
    cnt_t pend_beeps_reg, pend_beeps_next;
    cnt_t pend_on_reg, pend_on_next;
    cnt_t pend_off_reg, pend_off_next;
    logic req_pend_reg, req_pend_next;
    logic mute_seen_reg, mute_seen_next;
    logic tone_pin_reg, tone_pin_next;

    logic s_take;
    logic advance;

    // working values of a slow tick after the load step
    logic suppress;
    cnt_t ld_on, ld_off, ld_beeps, ld_on_rl, ld_off_rl;

    // the held item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        on_left_next    = on_left_reg;
        off_left_next   = off_left_reg;
        beeps_left_next = beeps_left_reg;
        on_reload_next  = on_reload_reg;
        off_reload_next = off_reload_reg;
        pend_beeps_next = pend_beeps_reg;
        pend_on_next    = pend_on_reg;
        pend_off_next   = pend_off_reg;
        req_pend_next   = req_pend_reg;
        mute_seen_next  = mute_seen_reg;
        tone_pin_next   = tone_pin_reg;

        // mute check: a change always allows the load, steady mute blocks it
        suppress  = (in_mute_reg == mute_seen_reg) && in_mute_reg;
        ld_on     = on_left_reg;
        ld_off    = off_left_reg;
        ld_beeps  = beeps_left_reg;
        ld_on_rl  = on_reload_reg;
        ld_off_rl = off_reload_reg;
        if (req_pend_reg && !suppress) begin
            ld_on     = '0;
            ld_off    = '0;
            ld_beeps  = pend_beeps_reg;
            ld_on_rl  = pend_on_reg;
            ld_off_rl = pend_off_reg;
        end

        unique case (in_kind_reg)
            KIND_BEEP_REQ: begin
                // last request before a slow tick wins
                pend_beeps_next = in_beeps_reg;
                pend_on_next    = in_on_reg;
                pend_off_next   = in_off_reg;
                req_pend_next   = 1'b1;
            end
            KIND_SLOW_TICK: begin
                mute_seen_next  = in_mute_reg;
                req_pend_next   = 1'b0;
                on_reload_next  = ld_on_rl;
                off_reload_next = ld_off_rl;
                on_left_next    = ld_on;
                off_left_next   = ld_off;
                beeps_left_next = ld_beeps;
                // countdown: on phase, then off phase, then start next beep
                priority if (ld_on != '0) begin
                    on_left_next = ld_on - cnt_t'(1);
                end else if (ld_off != '0) begin
                    off_left_next = ld_off - cnt_t'(1);
                end else if (ld_beeps != '0) begin
                    beeps_left_next = ld_beeps - cnt_t'(1);
                    on_left_next    = ld_on_rl;
                    off_left_next   = ld_off_rl;
                end
            end
            KIND_TONE_TICK: begin
                tone_pin_next = (on_left_reg != '0) ? !tone_pin_reg : 1'b0;
            end
            default: begin
                // unused kind only reports
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            on_left_reg    <= '0;
            off_left_reg   <= '0;
            beeps_left_reg <= '0;
            on_reload_reg  <= '0;
            off_reload_reg <= '0;
            pend_beeps_reg <= '0;
            pend_on_reg    <= '0;
            pend_off_reg   <= '0;
            req_pend_reg   <= 1'b0;
            mute_seen_reg  <= 1'b0;
            tone_pin_reg   <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance) begin
                on_left_reg    <= on_left_next;
                off_left_reg   <= off_left_next;
                beeps_left_reg <= beeps_left_next;
                on_reload_reg  <= on_reload_next;
                off_reload_reg <= off_reload_next;
                pend_beeps_reg <= pend_beeps_next;
                pend_on_reg    <= pend_on_next;
                pend_off_reg   <= pend_off_next;
                req_pend_reg   <= req_pend_next;
                mute_seen_reg  <= mute_seen_next;
                tone_pin_reg   <= tone_pin_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_kind_reg  <= kind_t'(s_tuser);
            in_beeps_reg <= s_tdata[7:0];
            in_on_reg    <= s_tdata[15:8];
            in_off_reg   <= s_tdata[23:16];
            in_mute_reg  <= s_tdata[24];
        end
        if (advance) begin
            out_pin_reg   <= tone_pin_next;
            out_sound_reg <= (on_left_next != '0);
            out_beeps_reg <= beeps_left_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_beeps_reg, out_sound_reg, out_pin_reg};

endmodule

/* rtl/bps_checker.sv */
// port-level checker for the beep pattern sequencer core, with its bind
`timescale 1ns / 1ps

module bps_checker
    import bps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [1:0] inflight_reg;
    logic       last_pin_reg;
    logic       s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            last_pin_reg <= 1'b0;
        end else begin
            inflight_reg <= inflight_reg + 2'(s_acc) - 2'(m_acc);
            if (m_acc) begin
                last_pin_reg <= m_tdata[0];
            end
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result without a request behind it
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != 2'd0)
        else $error("result without request");

    // at most two requests held inside
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3)
        else $error("more requests held than stages");

    // the pin only rises while the tone is sounding
    a_pin_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && m_tdata[0] && !last_pin_reg |-> m_tdata[1])
        else $error("pin rose while silent");

endmodule

bind beep_pattern_sequencer_core bps_checker u_bps_checker (.*);

/* tb/beep_pattern_sequencer_core_test.sv */
// testbench for the beep pattern sequencer core: directed table, random patterns, scoreboard
`timescale 1ns / 1ps

module beep_pattern_sequencer_core_test;
    import bps_pkg::*;

    localparam int ITEMS    = 1400;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        kind_t kind;
        cnt_t  beeps;
        cnt_t  on_len;
        cnt_t  off_len;
        logic  mute;
    } buzz_req_t;

    typedef struct packed {
        logic pin;
        logic snd;
        cnt_t left;
    } buzz_res_t;

    // one directed row; typed rows carry an expected result read off by hand
    typedef struct packed {
        kind_t kind;
        cnt_t  beeps;
        cnt_t  on_len;
        cnt_t  off_len;
        logic  mute;
        logic  typed;
        logic  pin;
        logic  snd;
        cnt_t  left;
    } dir_row_t;

    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        // straight out of reset, everything idle
        '{KIND_UNUSED,    8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        // two requests before a tick, the second wins
        '{KIND_BEEP_REQ,  8'd2,  8'd2,  8'd1,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        '{KIND_BEEP_REQ,  8'd3,  8'd3,  8'd1,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        // full-scale request loaded in the middle of a beep, mute rising
        '{KIND_BEEP_REQ,  8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        // request dropped while mute is held
        '{KIND_BEEP_REQ,  8'd1,  8'd1,  8'd0,  1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        // all-zero request clears the running pattern
        '{KIND_BEEP_REQ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0},
        // unused kind and unused fields must be ignored
        '{KIND_UNUSED,    8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_BEEP_REQ,  8'd1,  8'd1,  8'd1,  1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_TONE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        // tone tick with the on counter run out drives the pin low
        '{KIND_TONE_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0},
        '{KIND_SLOW_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0}
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // buzzer state as the block should hold it
    cnt_t on_cnt     = '0;
    cnt_t off_cnt    = '0;
    cnt_t beep_cnt   = '0;
    cnt_t on_len_q   = '0;
    cnt_t off_len_q  = '0;
    cnt_t held_beeps = '0;
    cnt_t held_on    = '0;
    cnt_t held_off   = '0;
    logic req_waiting = 1'b0;
    logic mute_level  = 1'b0;
    logic pin_q       = 1'b0;

    buzz_res_t buzzer_expect_q [$];
    int        fail_cnt  = 0;
    int        sent_cnt  = 0;
    int        burst_left = 0;
    logic      mute_drive = 1'b0;

    beep_pattern_sequencer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // advance the buzzer state by one request and report the outputs after it
    function automatic buzz_res_t predict_buzzer(input buzz_req_t r);
        logic      hold_load;
        buzz_res_t res;
        hold_load = 1'b0;
        case (r.kind)
            KIND_BEEP_REQ: begin
                held_beeps  = r.beeps;
                held_on     = r.on_len;
                held_off    = r.off_len;
                req_waiting = 1'b1;
            end
            KIND_SLOW_TICK: begin
                // a mute edge lets the load through, a steady mute blocks it
                if (r.mute != mute_level) begin
                    mute_level = r.mute;
                end else if (r.mute) begin
                    hold_load = 1'b1;
                end
                if (req_waiting) begin
                    req_waiting = 1'b0;
                    if (!hold_load) begin
                        on_cnt    = '0;
                        off_cnt   = '0;
                        beep_cnt  = held_beeps;
                        on_len_q  = held_on;
                        off_len_q = held_off;
                    end
                end
                if (on_cnt != 0) begin
                    on_cnt = on_cnt - 8'd1;
                end else if (off_cnt != 0) begin
                    off_cnt = off_cnt - 8'd1;
                end else if (beep_cnt != 0) begin
                    beep_cnt = beep_cnt - 8'd1;
                    on_cnt   = on_len_q;
                    off_cnt  = off_len_q;
                end
            end
            KIND_TONE_TICK: begin
                pin_q = (on_cnt != 0) ? ~pin_q : 1'b0;
            end
            default: ;
        endcase
        res.pin  = pin_q;
        res.snd  = (on_cnt != 0);
        res.left = beep_cnt;
        return res;
    endfunction

    function automatic buzz_req_t rand_req(input kind_t k);
        buzz_req_t r;
        r.kind    = k;
        r.beeps   = cnt_t'($urandom_range(0, 255));
        r.on_len  = cnt_t'($urandom_range(0, 255));
        r.off_len = cnt_t'($urandom_range(0, 255));
        r.mute    = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge after the request is taken
    task automatic send_item(input buzz_req_t r, input logic use_typed, input buzz_res_t typed_res);
        buzz_res_t pred;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.mute, r.off_len, r.on_len, r.beeps};
        s_tuser  <= r.kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = predict_buzzer(r);
        buzzer_expect_q.push_back(use_typed ? typed_res : pred);
        sent_cnt++;
        burst_left--;
        @(negedge aclk);
    endtask

    // hold the sender until every outstanding result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (buzzer_expect_q.size() != 0) @(negedge aclk);
    endtask

    // well-formed pattern: request(s), then slow ticks with tone ticks between them
    task automatic play_pattern();
        buzz_req_t r;
        int        n_slow;
        r = rand_req(KIND_BEEP_REQ);
        if ($urandom_range(0, 9) != 0) begin
            r.beeps   = cnt_t'($urandom_range(0, 4));
            r.on_len  = cnt_t'($urandom_range(0, 5));
            r.off_len = cnt_t'($urandom_range(0, 4));
        end
        send_item(r, 1'b0, '0);
        if ($urandom_range(0, 6) == 0) send_item(rand_req(KIND_BEEP_REQ), 1'b0, '0);
        n_slow = $urandom_range(1, 30);
        for (int i = 0; i < n_slow; i++) begin
            // mute mostly steady, with an occasional edge
            if ($urandom_range(0, 11) == 0) mute_drive = ~mute_drive;
            r = rand_req(KIND_SLOW_TICK);
            r.mute = mute_drive;
            send_item(r, 1'b0, '0);
            repeat ($urandom_range(0, 3)) send_item(rand_req(KIND_TONE_TICK), 1'b0, '0);
            if ($urandom_range(0, 19) == 0) send_item(rand_req(KIND_BEEP_REQ), 1'b0, '0);
        end
    endtask

    // receiver: ready follows a 32-bit pattern that is redrawn once all of its bits are used
    logic [31:0] rdy_pat = '1;
    int          rdy_idx = 0;

    always @(negedge aclk) begin
        if (rdy_idx == 0) begin
            case ($urandom_range(0, 3))
                0: rdy_pat = '1;
                1: rdy_pat = $urandom;
                2: rdy_pat = $urandom | $urandom;
                default: rdy_pat = ($urandom & $urandom) | 32'h0000_0001;
            endcase
        end
        m_tready <= rdy_pat[rdy_idx];
        rdy_idx = (rdy_idx + 1) % 32;
    end

    // scoreboard: each taken result against the oldest expectation
    always @(posedge aclk) begin
        buzz_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (buzzer_expect_q.size() == 0) begin
                $error("result with no request outstanding: m_tdata %h", m_tdata);
                fail_cnt++;
            end else begin
                want = buzzer_expect_q.pop_front();
                if (m_tdata[0] !== want.pin) begin
                    $error("pin_level: expected %0d, got %0d", want.pin, m_tdata[0]);
                    fail_cnt++;
                end
                if (m_tdata[1] !== want.snd) begin
                    $error("sounding: expected %0d, got %0d", want.snd, m_tdata[1]);
                    fail_cnt++;
                end
                if (m_tdata[9:2] !== want.left) begin
                    $error("beeps_remaining: expected %0d, got %0d", want.left, m_tdata[9:2]);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        dir_row_t  row;
        buzz_req_t r;
        buzz_res_t t;
        int        pause_at;
        logic      paused;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row       = DIR_TBL[i];
            r.kind    = row.kind;
            r.beeps   = row.beeps;
            r.on_len  = row.on_len;
            r.off_len = row.off_len;
            r.mute    = row.mute;
            t.pin     = row.pin;
            t.snd     = row.snd;
            t.left    = row.left;
            send_item(r, row.typed, t);
        end
        wait_drained();

        pause_at = $urandom_range(400, 1000);
        paused   = 1'b0;
        while (sent_cnt < ITEMS) begin
            if (!paused && sent_cnt >= pause_at) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                play_pattern();
            end else begin
                // noise: any kind, any field values
                repeat ($urandom_range(1, 6))
                    send_item(rand_req(kind_t'($urandom_range(0, 3))), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (buzzer_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
